>>> rtl/bch_pkg.sv
// Shared types and constants for the brightness/contrast histogram block.
// Used by bch_ctrl, bch_datapath and the top level; depends on nothing.
`default_nettype none

package bch_pkg;

    // Histogram geometry and defaults for the top-level parameters.
    localparam int BINS            = 256;
    localparam int IDX_W           = 8;
    localparam int COUNT_BITS_DEF  = 21;
    localparam int PLOT_HEIGHT_DEF = 400;

    // Fixed-point widths: gain is unsigned Q8.16, offset is signed Q17.16.
    localparam int A_W    = 24;
    localparam int B_W    = 34;
    localparam int FRAC_W = 16;
    localparam int COEF_NUM_W = 40;
    localparam int COEF_DEN_W = 16;

    // Register reset value and saturation limit.
    localparam logic [7:0] REG_NEUTRAL = 8'd100;
    localparam logic [7:0] REG_LIMIT   = 8'd200;

    // Register indexes on the configuration port.
    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_CONTRAST   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel_in;
        logic [7:0] bin_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic [8:0] bin_height;
    } out_item_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_COEF_PREP,
        OP_DIV_A,
        OP_A_LOAD,
        OP_DIV_B,
        OP_B_LOAD,
        OP_PIX_MUL,
        OP_PIX_ADD,
        OP_PIX_RD,
        OP_PIX_WR,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_BIN_RD,
        OP_BIN_PREP,
        OP_DIV_BIN,
        OP_BIN_RES,
        OP_CLEAR,
        OP_ZERO_RES
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       div_done;
        logic       scan_last;
        logic       flat;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COEF_PREP,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_B,
        ST_WAIT_B,
        ST_PIX_MUL,
        ST_PIX_ADD,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_END,
        ST_BIN_RD,
        ST_BIN_PREP,
        ST_BIN_CHK,
        ST_DIV_BIN,
        ST_WAIT_BIN,
        ST_CLEAR,
        ST_ZERO,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/bch_div.sv
// Iterative unsigned divider, one quotient bit per cycle, rounded to nearest with ties to even.
// Standalone; no package dependencies.
`default_nettype none

module bch_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 21
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   twice;
    logic             ge;

    // One restoring step per cycle, then a rounding step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, acc_reg[NUM_W-1]};
        twice     = {rem_reg, 1'b0};
        ge        = (trial >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            acc_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                acc_next = {acc_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                if ((twice > {1'b0, den_reg}) ||
                    ((twice == {1'b0, den_reg}) && acc_reg[0]))
                begin
                    acc_next = acc_reg + 1'b1;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = acc_reg;

endmodule

`default_nettype wire

>>> rtl/bch_datapath.sv
// Datapath: coefficient setup, pixel mapping, histogram memory, min/max scan and normalization.
// Depends on bch_pkg and bch_div.
`default_nettype none

module bch_datapath #(
    parameter int COUNT_BITS  = bch_pkg::COUNT_BITS_DEF,
    parameter int PLOT_HEIGHT = bch_pkg::PLOT_HEIGHT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bch_pkg::dp_cmd_t  cmd,
    output bch_pkg::dp_stat_t      stat,
    input  wire bch_pkg::in_item_t in_data,
    input  wire logic [7:0]        brightness,
    input  wire logic [7:0]        contrast,
    output bch_pkg::out_item_t     out_data
);

    localparam int PH_W    = $clog2(PLOT_HEIGHT + 1);
    localparam int BNUM_W  = COUNT_BITS + PH_W;
    localparam int NUM_W   = (BNUM_W > bch_pkg::COEF_NUM_W) ? BNUM_W : bch_pkg::COEF_NUM_W;
    localparam int DEN_W   = (COUNT_BITS > bch_pkg::COEF_DEN_W) ? COUNT_BITS
                                                                : bch_pkg::COEF_DEN_W;
    localparam int IDX_W   = bch_pkg::IDX_W;
    localparam int V_W     = 36;
    localparam int FL_W    = V_W - bch_pkg::FRAC_W;

    // Item and coefficient registers.
    bch_pkg::in_item_t          item_reg;
    logic [15:0]                cden_reg;
    logic [30:0]                anum_reg;
    logic [22:0]                bmag_reg;
    logic                       bneg_reg;
    logic [bch_pkg::A_W-1:0]    a_reg;
    logic signed [bch_pkg::B_W-1:0] b_reg;

    // Pixel pipeline registers.
    logic [31:0]                prod_reg;
    logic [IDX_W-1:0]           d_reg;

    // Histogram storage.
    logic [COUNT_BITS-1:0]      mem [bch_pkg::BINS];
    logic [bch_pkg::BINS-1:0]   vbits_reg;
    logic [COUNT_BITS-1:0]      rd_q;
    logic                       rd_vb_q;
    logic [COUNT_BITS-1:0]      rd_val;
    logic [IDX_W-1:0]           raddr;

    // Scan and normalization.
    logic [IDX_W-1:0]           scan_cnt_reg;
    logic                       scan_pend_reg;
    logic                       mm_first_reg;
    logic [COUNT_BITS-1:0]      lo_reg;
    logic [COUNT_BITS-1:0]      hi_reg;
    logic [NUM_W-1:0]           bnum_reg;
    logic [COUNT_BITS-1:0]      bden_reg;
    logic                       flat_reg;

    // Result registers.
    logic [7:0]                 res_pix_reg;
    logic [8:0]                 res_bin_reg;
    bch_pkg::out_item_t         out_reg;

    // Divider connections.
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic [NUM_W-1:0]           div_q;

    // Coefficient setup terms.
    logic [7:0]                 bs_u;
    logic [7:0]                 cs_u;
    logic signed [8:0]          bv_s;
    logic signed [8:0]          c_s;
    logic                       c_pos;
    logic [6:0]                 k_u;
    logic [6:0]                 cp_u;
    logic [14:0]                g_u;
    logic [15:0]                den_pos;
    logic signed [15:0]         bv16;
    logic signed [15:0]         c16;
    logic signed [15:0]         t_pos;
    logic signed [23:0]         s_pos;
    logic signed [23:0]         s_neg;
    logic signed [23:0]         s_sel;
    logic [23:0]                s_mag;

    // Pixel mapping terms.
    logic signed [V_W-1:0]      v_s;
    logic signed [FL_W-1:0]     fl_s;
    logic [bch_pkg::FRAC_W-1:0] frac_u;
    logic                       rnd_up;
    logic signed [FL_W:0]       fr_s;
    logic [7:0]                 d_sat;
    logic [COUNT_BITS-1:0]      cnt_inc;
    logic [BNUM_W-1:0]          bin_prod;

    // Gain and offset numerators and their divisor from the saturated register values.
    always_comb
    begin
        bs_u    = (brightness > bch_pkg::REG_LIMIT) ? bch_pkg::REG_LIMIT : brightness;
        cs_u    = (contrast > bch_pkg::REG_LIMIT) ? bch_pkg::REG_LIMIT : contrast;
        bv_s    = $signed({1'b0, bs_u}) - 9'sd100;
        c_s     = $signed({1'b0, cs_u}) - 9'sd100;
        c_pos   = (c_s > 9'sd0);
        k_u     = c_pos ? 7'd0 : 7'(-c_s);
        cp_u    = c_pos ? c_s[6:0] : 7'd0;
        g_u     = 15'd25600 - {k_u, 8'b0};
        den_pos = 16'd25500 - 16'(cp_u * 8'd254);
        bv16    = 16'(bv_s);
        c16     = 16'(c_s);
        t_pos   = bv16 * 16'sd100 - c16 * 16'sd127;
        s_pos   = 24'(t_pos) * 24'sd255;
        s_neg   = $signed({9'b0, g_u}) * 24'(bv_s) + 24'sd32640 * $signed({17'b0, k_u});
        s_sel   = c_pos ? s_pos : s_neg;
        s_mag   = s_sel[23] ? 24'(-s_sel) : 24'(s_sel);
    end

    // Pixel rounding to nearest with ties to even, then saturation.
    always_comb
    begin
        v_s    = $signed({4'b0, prod_reg}) + V_W'(b_reg);
        fl_s   = v_s[V_W-1:bch_pkg::FRAC_W];
        frac_u = v_s[bch_pkg::FRAC_W-1:0];
        rnd_up = (frac_u > 16'h8000) || ((frac_u == 16'h8000) && fl_s[0]);
        fr_s   = (FL_W+1)'(fl_s) + $signed({{FL_W{1'b0}}, rnd_up});
        if (fr_s < 0)
        begin
            d_sat = 8'd0;
        end
        else if (fr_s > (FL_W+1)'(255))
        begin
            d_sat = 8'd255;
        end
        else
        begin
            d_sat = fr_s[7:0];
        end
    end

    assign rd_val   = rd_vb_q ? rd_q : '0;
    assign cnt_inc  = (rd_val == {COUNT_BITS{1'b1}}) ? rd_val : rd_val + 1'b1;
    assign bin_prod = BNUM_W'(rd_val - lo_reg) * BNUM_W'(PLOT_HEIGHT);

    // Memory read address follows the operation.
    always_comb
    begin
        case (cmd.op)
            bch_pkg::OP_SCAN_RD: raddr = scan_cnt_reg;
            bch_pkg::OP_BIN_RD:  raddr = item_reg.bin_index;
            default:             raddr = d_reg;
        endcase
    end

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUM_W'(anum_reg);
        div_den   = DEN_W'(cden_reg);
        case (cmd.op)
            bch_pkg::OP_DIV_A:
            begin
                div_start = 1'b1;
            end
            bch_pkg::OP_DIV_B:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({bmag_reg, 16'b0});
            end
            bch_pkg::OP_DIV_BIN:
            begin
                div_start = 1'b1;
                div_num   = bnum_reg;
                div_den   = DEN_W'(bden_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bch_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    // Histogram memory: one read and one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.op == bch_pkg::OP_PIX_WR)
        begin
            mem[d_reg] <= cnt_inc;
        end
        rd_q    <= mem[raddr];
        rd_vb_q <= vbits_reg[raddr];
    end

    // Per-bin valid bits stand in for zeroed entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg <= '0;
        end
        else if (cmd.op == bch_pkg::OP_CLEAR)
        begin
            vbits_reg <= '0;
        end
        else if (cmd.op == bch_pkg::OP_PIX_WR)
        begin
            vbits_reg[d_reg] <= 1'b1;
        end
    end

    // Scan control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            scan_pend_reg <= 1'b0;
            mm_first_reg  <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= (cmd.op == bch_pkg::OP_SCAN_RD);
            if (cmd.op == bch_pkg::OP_SCAN_INIT)
            begin
                scan_cnt_reg <= '0;
                mm_first_reg <= 1'b1;
            end
            else
            begin
                if (cmd.op == bch_pkg::OP_SCAN_RD)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (scan_pend_reg)
                begin
                    mm_first_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        // Running minimum and maximum over the scanned bins.
        if (scan_pend_reg)
        begin
            if (mm_first_reg || (rd_val < lo_reg))
            begin
                lo_reg <= rd_val;
            end
            if (mm_first_reg || (rd_val > hi_reg))
            begin
                hi_reg <= rd_val;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.pixel_out  <= res_pix_reg;
            out_reg.bin_height <= res_bin_reg;
        end
        case (cmd.op)
            bch_pkg::OP_LOAD:
            begin
                item_reg <= in_data;
            end
            bch_pkg::OP_COEF_PREP:
            begin
                cden_reg <= c_pos ? den_pos : 16'd25500;
                anum_reg <= c_pos ? 31'(25500 * 65536) : {g_u, 16'b0};
                bmag_reg <= s_mag[22:0];
                bneg_reg <= s_sel[23];
            end
            bch_pkg::OP_A_LOAD:
            begin
                a_reg <= div_q[bch_pkg::A_W-1:0];
            end
            bch_pkg::OP_B_LOAD:
            begin
                b_reg <= bneg_reg ? -$signed(div_q[bch_pkg::B_W-1:0])
                                  : $signed(div_q[bch_pkg::B_W-1:0]);
            end
            bch_pkg::OP_PIX_MUL:
            begin
                prod_reg <= a_reg * item_reg.pixel_in;
            end
            bch_pkg::OP_PIX_ADD:
            begin
                d_reg <= d_sat;
            end
            bch_pkg::OP_PIX_WR:
            begin
                res_pix_reg <= d_reg;
                res_bin_reg <= '0;
            end
            bch_pkg::OP_BIN_PREP:
            begin
                bnum_reg <= NUM_W'(bin_prod);
                bden_reg <= hi_reg - lo_reg;
                flat_reg <= (hi_reg == lo_reg);
            end
            bch_pkg::OP_BIN_RES:
            begin
                res_pix_reg <= '0;
                res_bin_reg <= div_q[8:0];
            end
            bch_pkg::OP_CLEAR, bch_pkg::OP_ZERO_RES:
            begin
                res_pix_reg <= '0;
                res_bin_reg <= '0;
            end
            default:
            begin
                res_pix_reg <= res_pix_reg;
            end
        endcase
    end

    assign stat.func      = item_reg.func;
    assign stat.div_done  = div_done;
    assign stat.scan_last = (scan_cnt_reg == {IDX_W{1'b1}});
    assign stat.flat      = flat_reg;
    assign out_data       = out_reg;

    // The divider is only started when it is free.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A clear leaves every bin reading as zero.
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bch_pkg::OP_CLEAR) |=> (vbits_reg == '0))
        else $error("histogram not cleared");

    // The scan ends with a consistent range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bch_pkg::OP_BIN_PREP) |-> (lo_reg <= hi_reg))
        else $error("bin minimum above maximum");

    // A normalized height never exceeds the plot height.
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bch_pkg::OP_BIN_RES) |-> (div_q <= NUM_W'(PLOT_HEIGHT)))
        else $error("normalized height out of range");

endmodule

`default_nettype wire

>>> rtl/bch_ctrl.sv
// Controller state machine: sequences the datapath for each item and owns the output handshake.
// Depends on bch_pkg.
`default_nettype none

module bch_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire logic              cfg_wr,
    input  wire bch_pkg::dp_stat_t stat,
    output bch_pkg::dp_cmd_t       cmd
);

    bch_pkg::state_t state_reg, state_next;
    logic            coef_ok_reg, coef_ok_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bch_pkg::ST_IDLE;
            coef_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coef_ok_reg   <= coef_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        coef_ok_next   = coef_ok_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = bch_pkg::OP_NONE;
        cmd.out_load   = 1'b0;
        case (state_reg)
            bch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = bch_pkg::OP_LOAD;
                    state_next = bch_pkg::ST_DISPATCH;
                end
            end
            bch_pkg::ST_DISPATCH:
            begin
                case (bch_pkg::func_t'(stat.func))
                    bch_pkg::FUNC_PIXEL:
                        state_next = coef_ok_reg ? bch_pkg::ST_PIX_MUL
                                                 : bch_pkg::ST_COEF_PREP;
                    bch_pkg::FUNC_READ:  state_next = bch_pkg::ST_SCAN_INIT;
                    bch_pkg::FUNC_CLEAR: state_next = bch_pkg::ST_CLEAR;
                    default:             state_next = bch_pkg::ST_ZERO;
                endcase
            end
            bch_pkg::ST_COEF_PREP:
            begin
                cmd.op     = bch_pkg::OP_COEF_PREP;
                state_next = bch_pkg::ST_DIV_A;
            end
            bch_pkg::ST_DIV_A:
            begin
                cmd.op     = bch_pkg::OP_DIV_A;
                state_next = bch_pkg::ST_WAIT_A;
            end
            bch_pkg::ST_WAIT_A:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = bch_pkg::OP_A_LOAD;
                    state_next = bch_pkg::ST_DIV_B;
                end
            end
            bch_pkg::ST_DIV_B:
            begin
                cmd.op     = bch_pkg::OP_DIV_B;
                state_next = bch_pkg::ST_WAIT_B;
            end
            bch_pkg::ST_WAIT_B:
            begin
                if (stat.div_done)
                begin
                    cmd.op       = bch_pkg::OP_B_LOAD;
                    coef_ok_next = 1'b1;
                    state_next   = bch_pkg::ST_PIX_MUL;
                end
            end
            bch_pkg::ST_PIX_MUL:
            begin
                cmd.op     = bch_pkg::OP_PIX_MUL;
                state_next = bch_pkg::ST_PIX_ADD;
            end
            bch_pkg::ST_PIX_ADD:
            begin
                cmd.op     = bch_pkg::OP_PIX_ADD;
                state_next = bch_pkg::ST_PIX_RD;
            end
            bch_pkg::ST_PIX_RD:
            begin
                cmd.op     = bch_pkg::OP_PIX_RD;
                state_next = bch_pkg::ST_PIX_WR;
            end
            bch_pkg::ST_PIX_WR:
            begin
                cmd.op     = bch_pkg::OP_PIX_WR;
                state_next = bch_pkg::ST_DONE;
            end
            bch_pkg::ST_SCAN_INIT:
            begin
                cmd.op     = bch_pkg::OP_SCAN_INIT;
                state_next = bch_pkg::ST_SCAN_RD;
            end
            bch_pkg::ST_SCAN_RD:
            begin
                cmd.op = bch_pkg::OP_SCAN_RD;
                if (stat.scan_last)
                begin
                    state_next = bch_pkg::ST_SCAN_END;
                end
            end
            bch_pkg::ST_SCAN_END:
            begin
                state_next = bch_pkg::ST_BIN_RD;
            end
            bch_pkg::ST_BIN_RD:
            begin
                cmd.op     = bch_pkg::OP_BIN_RD;
                state_next = bch_pkg::ST_BIN_PREP;
            end
            bch_pkg::ST_BIN_PREP:
            begin
                cmd.op     = bch_pkg::OP_BIN_PREP;
                state_next = bch_pkg::ST_BIN_CHK;
            end
            bch_pkg::ST_BIN_CHK:
            begin
                state_next = stat.flat ? bch_pkg::ST_ZERO : bch_pkg::ST_DIV_BIN;
            end
            bch_pkg::ST_DIV_BIN:
            begin
                cmd.op     = bch_pkg::OP_DIV_BIN;
                state_next = bch_pkg::ST_WAIT_BIN;
            end
            bch_pkg::ST_WAIT_BIN:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = bch_pkg::OP_BIN_RES;
                    state_next = bch_pkg::ST_DONE;
                end
            end
            bch_pkg::ST_CLEAR:
            begin
                cmd.op     = bch_pkg::OP_CLEAR;
                state_next = bch_pkg::ST_DONE;
            end
            bch_pkg::ST_ZERO:
            begin
                cmd.op     = bch_pkg::OP_ZERO_RES;
                state_next = bch_pkg::ST_DONE;
            end
            bch_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bch_pkg::ST_IDLE;
            end
        endcase
        // Any register write makes the gain and offset stale.
        if (cfg_wr)
        begin
            coef_ok_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != bch_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/brightness_contrast_histogram.sv
// Top level: register port, controller and datapath of the brightness/contrast histogram.
// Depends on bch_pkg, bch_ctrl and bch_datapath.
//
// Usage:
// Items enter on in_valid/in_stall/in_data and one result per item leaves on
// out_valid/out_stall/out_data; an item is taken when valid is high and stall low.
// func 0 maps a pixel through the gain and offset and counts it, func 1 returns
// one bin normalized to 0..PLOT_HEIGHT, func 2 clears the histogram, func 3
// returns zeros. One item is worked on at a time; in_stall is low only while idle.
// After a register write the first pixel also recomputes gain and offset with two
// serial divisions. A bin read scans all 256 bins through the memory read port,
// one per cycle, then runs one serial division unless all bins hold the same count,
// in which case it returns zero.
// The result sits in an output register, so the next item is taken while it waits;
// a stalled receiver holds only the item that finishes after it.
// Reset empties the histogram at once through per-bin valid bits, sets both
// registers to 100 and drops out_valid. Registers are to be written only while
// idle; the block itself does not enforce this.
`default_nettype none

module brightness_contrast_histogram #(
    parameter int COUNT_BITS  = bch_pkg::COUNT_BITS_DEF,
    parameter int PLOT_HEIGHT = bch_pkg::PLOT_HEIGHT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bch_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bch_pkg::out_item_t     out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [7:0]        bright_reg;
    logic [7:0]        contr_reg;
    logic              cfg_wr;
    bch_pkg::dp_cmd_t  cmd;
    bch_pkg::dp_stat_t stat;

    // Register writes complete in the access phase.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= bch_pkg::REG_NEUTRAL;
            contr_reg  <= bch_pkg::REG_NEUTRAL;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bch_pkg::REG_BRIGHTNESS)
            begin
                bright_reg <= pwdata[7:0];
            end
            else
            begin
                contr_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'b0, (paddr[2] == bch_pkg::REG_CONTRAST) ? contr_reg : bright_reg};
    assign pready = 1'b1;

    bch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_wr    (cfg_wr),
        .stat      (stat),
        .cmd       (cmd)
    );

    bch_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .PLOT_HEIGHT (PLOT_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (in_data),
        .brightness (bright_reg),
        .contrast   (contr_reg),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
